// ===== sv/sdz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick dead zone package
// Shared constants, register codes and the lane control bundle.
// ----------------------------------------------------------------------------
package sdz_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int THRESH_W          = 15;
  localparam int MODE_W            = 2;
  localparam int KIND_W            = 2;
  localparam int CFG_IDX_W         = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_AXIAL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RADIAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNSCALED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_BOOL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ONE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TWO   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_THREE = 2'd3;

  localparam logic [THRESH_W-1:0] LOWER_RST = 15'd3277;
  localparam logic [THRESH_W-1:0] UPPER_RST = 15'd16384;
  localparam logic [MODE_W-1:0]   MODE_RST  = MODE_AXIAL;

  typedef struct packed {
    logic                use_remap;
    logic                scaled;
    logic [THRESH_W-1:0] lower;
    logic [THRESH_W-1:0] upper;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== sv/sdz_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, truncating, with a sideband carried alongside.
// ----------------------------------------------------------------------------
module sdz_sqrt #(
  parameter int SW = sdz_pkg::SAMPLE_WIDTH_DEF,
  parameter int DW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*SW-1:0] in_rad,
  input  wire logic [DW-1:0]   in_side,
  output logic                 out_valid,
  output logic [SW-1:0]        out_root,
  output logic [DW-1:0]        out_side
);

  logic [SW-1:0]   vld_r;
  logic [2*SW-1:0] rad_r  [SW];
  logic [SW+1:0]   rem_r  [SW];
  logic [SW-1:0]   root_r [SW];
  logic [DW-1:0]   side_r [SW];

  logic [SW-1:0]   vld_src;
  logic [2*SW-1:0] rad_src  [SW];
  logic [SW+1:0]   rem_src  [SW];
  logic [SW-1:0]   root_src [SW];
  logic [DW-1:0]   side_src [SW];

  logic [2*SW-1:0] rad_nxt  [SW];
  logic [SW+1:0]   rem_nxt  [SW];
  logic [SW-1:0]   root_nxt [SW];
  logic [SW+1:0]   acc      [SW];
  logic [SW+1:0]   trial    [SW];
  logic [SW-1:0]   fit;

  always_comb begin
    vld_src[0]  = in_valid;
    rad_src[0]  = in_rad;
    rem_src[0]  = '0;
    root_src[0] = '0;
    side_src[0] = in_side;
    for (int k = 1; k < SW; k++) begin
      vld_src[k]  = vld_r[k-1];
      rad_src[k]  = rad_r[k-1];
      rem_src[k]  = rem_r[k-1];
      root_src[k] = root_r[k-1];
      side_src[k] = side_r[k-1];
    end
    for (int k = 0; k < SW; k++) begin
      acc[k]      = {rem_src[k][SW-1:0], rad_src[k][2*SW-1 -: 2]};
      trial[k]    = {root_src[k], 2'b01};
      fit[k]      = (acc[k] >= trial[k]);
      rem_nxt[k]  = fit[k] ? (acc[k] - trial[k]) : acc[k];
      root_nxt[k] = {root_src[k][SW-2:0], fit[k]};
      rad_nxt[k]  = rad_src[k] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_src;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SW; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= side_src[k];
      end
    end
  end

  assign out_valid = vld_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_side  = side_r[SW-1];

endmodule
`default_nettype wire

// ===== sv/sdz_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dead zone lane
// Remaps a magnitude, then scales one axis by remap/magnitude.
// ----------------------------------------------------------------------------
module sdz_lane #(
  parameter int SW = sdz_pkg::SAMPLE_WIDTH_DEF,
  parameter int FB = sdz_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [SW-1:0]    in_axis,
  input  wire logic [SW-1:0]           in_den,
  input  wire sdz_pkg::lane_ctl_t      in_ctl,
  output logic                         out_valid,
  output logic signed [SW-1:0]         out_axis
);

  localparam int TW = sdz_pkg::THRESH_W;
  localparam int MW = (FB + 1 > TW) ? FB + 1 : TW;
  localparam int PW = SW + MW;
  localparam int EW = ((SW > TW) ? SW : TW) + 1;

  typedef struct packed {
    logic signed [SW-1:0] axis;
    logic [SW-1:0]        den;
    logic                 use_remap;
    logic                 div_sel;
    logic [MW-1:0]        m_const;
    logic [TW-1:0]        range;
  } car_t;

  typedef struct packed {
    logic signed [SW-1:0] axis;
    logic [SW-1:0]        den;
    logic                 use_remap;
  } tail_t;

  // Entry stage.
  logic [EW-1:0] den_e, lo_e, hi_e, d_e;
  logic [TW-1:0] range_w;
  logic          below_s, below_u, full;
  car_t          car_in;
  logic [TW-1:0] rem_in;

  always_comb begin
    den_e   = EW'(in_den);
    lo_e    = EW'(in_ctl.lower);
    hi_e    = EW'(in_ctl.upper);
    range_w = in_ctl.upper - in_ctl.lower;
    d_e     = den_e - lo_e;
    below_s = (den_e <= lo_e);
    below_u = (den_e < lo_e);
    full    = (d_e >= EW'(range_w));
    car_in.axis      = in_axis;
    car_in.den       = in_den;
    car_in.use_remap = in_ctl.use_remap;
    car_in.range     = range_w;
    car_in.div_sel   = in_ctl.scaled && !below_s && !full;
    if (in_ctl.scaled) begin
      car_in.m_const = (!below_s && full) ? (MW'(1) << FB) : '0;
    end else if (below_u) begin
      car_in.m_const = '0;
    end else if (den_e >= hi_e) begin
      car_in.m_const = MW'(in_ctl.upper);
    end else begin
      car_in.m_const = MW'(in_den);
    end
    rem_in = d_e[TW-1:0];
  end

  logic          ent_vld_r;
  car_t          ent_car_r;
  logic [TW-1:0] ent_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (en) begin
      ent_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_car_r <= car_in;
      ent_rem_r <= rem_in;
    end
  end

  // Remap divider: one quotient bit per stage.
  logic [FB-1:0] rv_r;
  car_t          rc_r   [FB];
  logic [TW-1:0] rrem_r [FB];
  logic [FB-1:0] rq_r   [FB];

  logic [FB-1:0] rv_src;
  car_t          rc_src   [FB];
  logic [TW-1:0] rrem_src [FB];
  logic [FB-1:0] rq_src   [FB];
  logic [TW:0]   racc     [FB];
  logic [FB-1:0] rfit;
  logic [TW-1:0] rrem_nxt [FB];
  logic [FB-1:0] rq_nxt   [FB];

  always_comb begin
    rv_src[0]   = ent_vld_r;
    rc_src[0]   = ent_car_r;
    rrem_src[0] = ent_rem_r;
    rq_src[0]   = '0;
    for (int k = 1; k < FB; k++) begin
      rv_src[k]   = rv_r[k-1];
      rc_src[k]   = rc_r[k-1];
      rrem_src[k] = rrem_r[k-1];
      rq_src[k]   = rq_r[k-1];
    end
    for (int k = 0; k < FB; k++) begin
      racc[k]     = {rrem_src[k], 1'b0};
      rfit[k]     = (racc[k] >= {1'b0, rc_src[k].range});
      rrem_nxt[k] = rfit[k] ? TW'(racc[k] - {1'b0, rc_src[k].range}) : TW'(racc[k]);
      rq_nxt[k]   = {rq_src[k][FB-2:0], rfit[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= '0;
    end else if (en) begin
      rv_r <= rv_src;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < FB; k++) begin
        rc_r[k]   <= rc_src[k];
        rrem_r[k] <= rrem_nxt[k];
        rq_r[k]   <= rq_nxt[k];
      end
    end
  end

  // Multiply stage.
  car_t          rc_last;
  logic [MW-1:0] m_sel;
  logic [SW-1:0] mag;
  tail_t         tail_in;

  always_comb begin
    rc_last = rc_r[FB-1];
    m_sel   = rc_last.div_sel ? MW'(rq_r[FB-1]) : rc_last.m_const;
    mag     = rc_last.axis[SW-1] ? SW'(-rc_last.axis) : SW'(rc_last.axis);
    tail_in.axis      = rc_last.axis;
    tail_in.den       = rc_last.den;
    tail_in.use_remap = rc_last.use_remap;
  end

  logic          mul_vld_r;
  logic [PW-1:0] mul_prod_r;
  tail_t         mul_tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (en) begin
      mul_vld_r <= rv_r[FB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_prod_r <= PW'(mag) * PW'(m_sel);
      mul_tail_r <= tail_in;
    end
  end

  // Product divider: quotient fits MW bits since the axis never exceeds the divisor.
  logic [MW-1:0] dv_r;
  tail_t         dt_r   [MW];
  logic [SW-1:0] drem_r [MW];
  logic [MW-1:0] dlow_r [MW];
  logic [MW-1:0] dq_r   [MW];

  logic [MW-1:0] dv_src;
  tail_t         dt_src   [MW];
  logic [SW-1:0] drem_src [MW];
  logic [MW-1:0] dlow_src [MW];
  logic [MW-1:0] dq_src   [MW];
  logic [SW:0]   dacc     [MW];
  logic [MW-1:0] dfit;
  logic [SW-1:0] drem_nxt [MW];
  logic [MW-1:0] dlow_nxt [MW];
  logic [MW-1:0] dq_nxt   [MW];

  always_comb begin
    dv_src[0]   = mul_vld_r;
    dt_src[0]   = mul_tail_r;
    drem_src[0] = mul_prod_r[PW-1:MW];
    dlow_src[0] = mul_prod_r[MW-1:0];
    dq_src[0]   = '0;
    for (int k = 1; k < MW; k++) begin
      dv_src[k]   = dv_r[k-1];
      dt_src[k]   = dt_r[k-1];
      drem_src[k] = drem_r[k-1];
      dlow_src[k] = dlow_r[k-1];
      dq_src[k]   = dq_r[k-1];
    end
    for (int k = 0; k < MW; k++) begin
      dacc[k]     = {drem_src[k], dlow_src[k][MW-1]};
      dfit[k]     = (dacc[k] >= {1'b0, dt_src[k].den});
      drem_nxt[k] = dfit[k] ? SW'(dacc[k] - {1'b0, dt_src[k].den}) : SW'(dacc[k]);
      dlow_nxt[k] = dlow_src[k] << 1;
      dq_nxt[k]   = {dq_src[k][MW-2:0], dfit[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= dv_src;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MW; k++) begin
        dt_r[k]   <= dt_src[k];
        drem_r[k] <= drem_nxt[k];
        dlow_r[k] <= dlow_nxt[k];
        dq_r[k]   <= dq_nxt[k];
      end
    end
  end

  // Sign restore and pass-through select.
  tail_t                dt_last;
  logic [SW-1:0]        q_sw;
  logic signed [SW-1:0] axis_nxt;
  logic                 out_valid_r;
  logic signed [SW-1:0] out_axis_r;

  always_comb begin
    dt_last = dt_r[MW-1];
    q_sw    = SW'(dq_r[MW-1]);
    if (!dt_last.use_remap || (dt_last.den == '0)) begin
      axis_nxt = dt_last.axis;
    end else if (dt_last.axis[SW-1]) begin
      axis_nxt = -$signed(q_sw);
    end else begin
      axis_nxt = $signed(q_sw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[MW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_axis_r <= axis_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_axis  = out_axis_r;

endmodule
`default_nettype wire

// ===== sv/stick_dead_zone.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick dead zone
// Axial, radial scaled and radial unscaled dead zone for up to three axes.
//
// A sample transfers on the input channel when in_valid and in_ready are
// both high; one result per sample transfers on the output channel in the
// same order. A new sample can be taken every cycle while the output is not
// stalled. Latency from input transfer to out_valid is set by the capture and
// sum stages, the square root pipeline and, per lane, the entry stage, the two
// dividers, each one bit per stage, the multiply stage and the output register,
// then the merge register. The whole pipeline advances together: while
// out_valid is high and out_ready is low, every stage holds and in_ready is
// low. Reset empties the pipeline and loads the threshold and mode registers
// with their defaults. Registers are written through cfg_we, cfg_index and
// cfg_wdata and should only change while no sample is in flight.
// ----------------------------------------------------------------------------
module stick_dead_zone #(
  parameter int SAMPLE_WIDTH  = sdz_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = sdz_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    in_axis_x,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    in_axis_y,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    in_axis_z,
  input  wire logic [sdz_pkg::KIND_W-1:0]        in_value_kind,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]         out_x,
  output logic signed [SAMPLE_WIDTH-1:0]         out_y,
  output logic signed [SAMPLE_WIDTH-1:0]         out_z,
  input  wire logic                              cfg_we,
  input  wire logic [sdz_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sdz_pkg::THRESH_W-1:0]      cfg_wdata
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int TW = sdz_pkg::THRESH_W;

  typedef struct packed {
    logic signed [SW-1:0] axis_x;
    logic signed [SW-1:0] axis_y;
    logic signed [SW-1:0] axis_z;
    logic [2:0]           use_remap;
    logic                 scaled;
    logic                 radial_multi;
    logic [TW-1:0]        lower;
    logic [TW-1:0]        upper;
  } side_t;

  localparam int DW = $bits(side_t);

  logic [TW-1:0]                lower_r, upper_r;
  logic [sdz_pkg::MODE_W-1:0]   mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= sdz_pkg::LOWER_RST;
      upper_r <= sdz_pkg::UPPER_RST;
      mode_r  <= sdz_pkg::MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sdz_pkg::CFG_LOWER: lower_r <= cfg_wdata;
        sdz_pkg::CFG_UPPER: upper_r <= cfg_wdata;
        sdz_pkg::CFG_MODE:  mode_r  <= cfg_wdata[sdz_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Capture stage: control decode, magnitudes and squares.
  side_t          side_in;
  logic           bypass, radial;
  logic [2:0]     active;
  logic [SW-1:0]  mag_x, mag_y, mag_z;

  always_comb begin
    bypass = (upper_r <= lower_r) || (mode_r == sdz_pkg::MODE_UNUSED);
    radial = (mode_r == sdz_pkg::MODE_RADIAL) || (mode_r == sdz_pkg::MODE_UNSCALED);
    active[0] = 1'b1;
    active[1] = (in_value_kind == sdz_pkg::KIND_TWO) || (in_value_kind == sdz_pkg::KIND_THREE);
    active[2] = (in_value_kind == sdz_pkg::KIND_THREE);
    side_in.axis_x       = in_axis_x;
    side_in.axis_y       = in_axis_y;
    side_in.axis_z       = in_axis_z;
    side_in.use_remap    = bypass ? 3'b000 : active;
    side_in.scaled       = (mode_r != sdz_pkg::MODE_UNSCALED);
    side_in.radial_multi = radial && active[1];
    side_in.lower        = lower_r;
    side_in.upper        = upper_r;
    mag_x = in_axis_x[SW-1] ? SW'(-in_axis_x) : SW'(in_axis_x);
    mag_y = in_axis_y[SW-1] ? SW'(-in_axis_y) : SW'(in_axis_y);
    mag_z = in_axis_z[SW-1] ? SW'(-in_axis_z) : SW'(in_axis_z);
  end

  logic            cap_vld_r;
  side_t           cap_side_r;
  logic [2*SW-1:0] sq_x_r, sq_y_r, sq_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= 1'b0;
    end else if (en) begin
      cap_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cap_side_r <= side_in;
      sq_x_r     <= (2*SW)'(mag_x) * (2*SW)'(mag_x);
      sq_y_r     <= side_in.radial_multi ? (2*SW)'(mag_y) * (2*SW)'(mag_y) : '0;
      sq_z_r     <= (side_in.radial_multi && active[2]) ?
                    (2*SW)'(mag_z) * (2*SW)'(mag_z) : '0;
    end
  end

  // Sum stage: three squares of at most 2^(2*SW-2) each stay below 2^(2*SW).
  logic            sum_vld_r;
  side_t           sum_side_r;
  logic [2*SW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (en) begin
      sum_vld_r <= cap_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_side_r <= cap_side_r;
      sum_r      <= sq_x_r + sq_y_r + sq_z_r;
    end
  end

  logic          sq_vld;
  logic [SW-1:0] sq_root;
  logic [DW-1:0] sq_side_vec;
  side_t         sq_side;

  sdz_sqrt #(
    .SW (SW),
    .DW (DW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sum_vld_r),
    .in_rad    (sum_r),
    .in_side   (sum_side_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side_vec)
  );

  assign sq_side = side_t'(sq_side_vec);

  // Lane inputs: radial vectors divide by their length, all else by |axis|.
  logic signed [SW-1:0] lane_axis [3];
  logic [SW-1:0]        lane_den  [3];
  sdz_pkg::lane_ctl_t   lane_ctl  [3];
  logic [2:0]           lane_vld;
  logic signed [SW-1:0] lane_out  [3];

  always_comb begin
    lane_axis[0] = sq_side.axis_x;
    lane_axis[1] = sq_side.axis_y;
    lane_axis[2] = sq_side.axis_z;
    for (int i = 0; i < 3; i++) begin
      if (sq_side.radial_multi) begin
        lane_den[i] = sq_root;
      end else begin
        lane_den[i] = lane_axis[i][SW-1] ? SW'(-lane_axis[i]) : SW'(lane_axis[i]);
      end
      lane_ctl[i].use_remap = sq_side.use_remap[i];
      lane_ctl[i].scaled    = sq_side.scaled;
      lane_ctl[i].lower     = sq_side.lower;
      lane_ctl[i].upper     = sq_side.upper;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sdz_lane #(
      .SW (SW),
      .FB (FRACTION_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_vld),
      .in_axis   (lane_axis[g]),
      .in_den    (lane_den[g]),
      .in_ctl    (lane_ctl[g]),
      .out_valid (lane_vld[g]),
      .out_axis  (lane_out[g])
    );
  end

  // Merge stage: the output register collects the three lanes.
  logic signed [SW-1:0] out_x_r, out_y_r, out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lane_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= lane_out[0];
      out_y_r <= lane_out[1];
      out_z_r <= lane_out[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_vld[0] == lane_vld[1]) && (lane_vld[1] == lane_vld[2]))
    else $error("dead zone lanes lost alignment");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input transfer possible while output is stalled");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

// ===== bench/tb_stick_dead_zone.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick dead zone testbench
// Drives samples through the dead zone block under random stalls on both
// channels, predicts every result in axial, radial and unscaled modes and
// compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_stick_dead_zone;
  import sdz_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int LATENCY = 51;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
  } axes_t;

  class deadzone_board;
    axes_t pending[$];
    logic [THRESH_W-1:0] lower;
    logic [THRESH_W-1:0] upper;
    logic [MODE_W-1:0] mode;
    int errors;
    int checked;

    function new();
      lower = LOWER_RST;
      upper = UPPER_RST;
      mode = MODE_RST;
      errors = 0;
      checked = 0;
    endfunction

    function longint shape_mag(longint m, bit scaled);
      longint d;
      longint q;
      if (scaled) begin
        d = m - lower;
        if (d <= 0) return 0;
        q = (d <<< FB) / (longint'(upper) - longint'(lower));
        return (q > (64'sd1 <<< FB)) ? (64'sd1 <<< FB) : q;
      end
      if (m < lower) return 0;
      return (m < upper) ? m : longint'(upper);
    endfunction

    function longint shape_signed(longint a, bit scaled);
      if (a < 0) return -shape_mag(-a, scaled);
      if (a > 0) return shape_mag(a, scaled);
      return 0;
    endfunction

    function longint root_floor(longint v);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v) r = r + (64'sd1 <<< b);
      end
      return r;
    endfunction

    function void note_sample(axes_t s, logic [KIND_W-1:0] kind);
      longint ax[3];
      longint sq;
      longint len;
      longint m;
      int n;
      bit scaled;
      axes_t r;
      ax[0] = s.x;
      ax[1] = s.y;
      ax[2] = s.z;
      n = (kind == KIND_THREE) ? 3 : ((kind == KIND_TWO) ? 2 : 1);
      scaled = (mode == MODE_RADIAL);
      if (upper > lower) begin
        if (mode == MODE_AXIAL) begin
          for (int i = 0; i < n; i++) ax[i] = shape_signed(ax[i], 1'b1);
        end else if (mode == MODE_RADIAL || mode == MODE_UNSCALED) begin
          if (n == 1) begin
            ax[0] = shape_signed(ax[0], scaled);
          end else begin
            sq = 0;
            for (int i = 0; i < n; i++) sq += ax[i] * ax[i];
            len = root_floor(sq);
            if (len > 0) begin
              m = shape_mag(len, scaled);
              for (int i = 0; i < n; i++) ax[i] = (ax[i] * m) / len;
            end
          end
        end
      end
      r.x = ax[0][SW-1:0];
      r.y = ax[1][SW-1:0];
      r.z = ax[2][SW-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(axes_t got);
      axes_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                   want.x, want.y, want.z, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SW-1:0] in_axis_x;
  logic signed [SW-1:0] in_axis_y;
  logic signed [SW-1:0] in_axis_z;
  logic [KIND_W-1:0] in_value_kind;
  logic out_valid;
  logic out_ready;
  logic signed [SW-1:0] out_x;
  logic signed [SW-1:0] out_y;
  logic signed [SW-1:0] out_z;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THRESH_W-1:0] cfg_wdata;

  deadzone_board board;
  int samples_sent;

  stick_dead_zone dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_value_kind(in_value_kind),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_LOWER: board.lower = val;
      CFG_UPPER: board.upper = val;
      default: board.mode = val[MODE_W-1:0];
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_zone(int lo, int hi, int md);
    drain();
    write_reg(CFG_LOWER, THRESH_W'(lo));
    write_reg(CFG_UPPER, THRESH_W'(hi));
    write_reg(CFG_MODE, THRESH_W'(md));
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(int x, int y, int z, logic [KIND_W-1:0] kind, bit noidle);
    int gap;
    axes_t s;
    gap = noidle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s.x = SW'(x);
    s.y = SW'(y);
    s.z = SW'(z);
    in_valid <= 1'b1;
    in_axis_x <= s.x;
    in_axis_y <= s.y;
    in_axis_z <= s.z;
    in_value_kind <= kind;
    do @(posedge clk); while (!in_ready);
    board.note_sample(s, kind);
    samples_sent++;
  endtask

  function automatic int pick_axis();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4000) - 2000;
      1: return -32768;
      2: return 32767;
      3: return 0;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  initial begin : output_side
    int stall;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result({out_x, out_y, out_z});
    end
  end

  initial begin : stimulus
    int lows[6];
    int highs[6];
    int setting;
    int waited;
    bit burst;
    board = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_axis_x <= '0;
    in_axis_y <= '0;
    in_axis_z <= '0;
    in_value_kind <= KIND_BOOL;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LOWER;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(32767, -32768, 0, KIND_THREE, 0);
    send_sample(-32768, 5, 7, KIND_ONE, 0);
    send_sample(0, 100, -100, KIND_TWO, 0);
    send_sample(3000, 3000, 3000, KIND_BOOL, 0);
    set_zone(3277, 16384, MODE_RADIAL);
    send_sample(0, 0, 0, KIND_THREE, 0);
    send_sample(-32768, -32768, -32768, KIND_THREE, 0);
    send_sample(20000, -15000, 0, KIND_TWO, 0);
    send_sample(-5000, 1, 1, KIND_ONE, 0);
    set_zone(1000, 30000, MODE_UNSCALED);
    send_sample(500, 500, 0, KIND_TWO, 0);
    send_sample(32767, 32767, 32767, KIND_THREE, 0);
    send_sample(-2000, 0, 0, KIND_ONE, 0);
    set_zone(20000, 20000, MODE_AXIAL);
    send_sample(12345, -23456, 32767, KIND_THREE, 0);
    set_zone(0, 32767, MODE_UNUSED);
    send_sample(-1, 1, -32768, KIND_THREE, 0);
    set_zone(32767, 0, MODE_RADIAL);
    send_sample(9999, -9999, 0, KIND_TWO, 0);
    set_zone(0, 1, MODE_AXIAL);
    send_sample(1, -1, 0, KIND_TWO, 0);
    send_sample(-32768, 32767, 0, KIND_THREE, 0);

    lows = '{0, 3277, 0, 32766, 8000, 32767};
    highs = '{32767, 16384, 1, 32767, 8001, 32767};
    for (setting = 0; setting < 34; setting++) begin
      if (setting < 6) begin
        set_zone(lows[setting], highs[setting], setting % 4);
      end else begin
        set_zone($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 3));
      end
      burst = $urandom_range(0, 1);
      for (waited = 0; waited < 50; waited++) begin
        send_sample(pick_axis(), pick_axis(), pick_axis(), KIND_W'($urandom_range(0, 3)),
                    burst);
        if (setting == 10 && waited == 25) drain();
      end
    end
    in_valid <= 1'b0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (board.pending.size() != 0) board.errors += board.pending.size();
    $display("Sent %0d samples and checked %0d results over 40 threshold settings",
             samples_sent, board.checked);
    $display("in every zone mode, including empty ranges and extreme axis values.");
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
